>>> rtl/core/beoc_pkg.sv
// Shared types and constants for the binary erosion opening check.
`default_nettype none

package beoc_pkg;

	// input word operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	// configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;
	localparam logic [CFG_DATA_W-1:0] SIZE_RESET      = 8'd128;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RDATA,
		ST_SCAN
	} top_state_t;

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_RUN,
		SC_FLUSH,
		SC_DONE
	} scan_state_t;

	typedef struct packed {
		logic done;
		logic ok;
	} scan_status_t;

endpackage

`default_nettype wire

>>> rtl/core/binary_erosion_opening_check.sv
// Top level: loads a binary image, erodes it, checks the opening and reads it back.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  in      | in_valid/in_stall  | operation, pixel_black
//  out     | out_valid/out_stall| eroded_black, possible, last_pixel
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data (0 width, 1 height)
//
// A load writes the image memory; a read waits in ST_RDATA for the eroded memory's registered read.
// The final load starts a scan of two passes, three row reads per column each on
// the single read port of each memory.
// Reset clears positions, the flag and the handshake state; memories keep junk.
// A new word is taken only while idle and the output register is empty or being taken.
`default_nettype none

module binary_erosion_opening_check #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               operation,
	input  wire logic                               pixel_black,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    eroded_black,
	output logic                                    possible,
	output logic                                    last_pixel,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [beoc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [beoc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int CCW    = $clog2(MAX_WIDTH + 1);
	localparam int RCW    = $clog2(MAX_HEIGHT + 1);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int XW     = (CCW > beoc_pkg::CFG_DATA_W) ? CCW : beoc_pkg::CFG_DATA_W;
	localparam int XH     = (RCW > beoc_pkg::CFG_DATA_W) ? RCW : beoc_pkg::CFG_DATA_W;

	beoc_pkg::top_state_t              state_q, state_d;
	logic [beoc_pkg::CFG_DATA_W-1:0]   width_q;
	logic [beoc_pkg::CFG_DATA_W-1:0]   height_q;
	logic [ROW_W-1:0]                  ld_row_q;
	logic [COL_W-1:0]                  ld_col_q;
	logic [ROW_W-1:0]                  rd_row_q;
	logic [COL_W-1:0]                  rd_col_q;
	logic                              rd_last_q;
	logic                              possible_q;
	logic                              out_valid_q;
	logic                              eroded_q;
	logic                              possible_out_q;
	logic                              last_q;

	logic [XW-1:0]                     w_ext;
	logic [XH-1:0]                     h_ext;
	logic [CCW-1:0]                    eff_w;
	logic [RCW-1:0]                    eff_h;
	logic                              ld_col_end;
	logic                              ld_last;
	logic                              rd_col_end;
	logic                              rd_last;
	logic                              in_acc;
	logic                              cfg_acc;
	logic                              cfg_hit;
	logic                              scan_start;

	logic [ADDR_W-1:0]                 img_raddr;
	logic                              img_rdata;
	logic [ADDR_W-1:0]                 scan_ero_raddr;
	logic [ADDR_W-1:0]                 ero_raddr;
	logic                              ero_rdata;
	logic                              ero_we;
	logic [ADDR_W-1:0]                 ero_waddr;
	logic                              ero_wdata;
	beoc_pkg::scan_status_t            scan_status;

	// size registers clamp to 1..MAX
	always_comb begin
		w_ext = XW'(width_q);
		h_ext = XH'(height_q);
		if (w_ext == '0) begin
			eff_w = CCW'(1);
		end else if (w_ext > XW'(MAX_WIDTH)) begin
			eff_w = CCW'(MAX_WIDTH);
		end else begin
			eff_w = CCW'(w_ext);
		end
		if (h_ext == '0) begin
			eff_h = RCW'(1);
		end else if (h_ext > XH'(MAX_HEIGHT)) begin
			eff_h = RCW'(MAX_HEIGHT);
		end else begin
			eff_h = RCW'(h_ext);
		end
		ld_col_end = ((CCW'(ld_col_q) + CCW'(1)) == eff_w);
		ld_last    = ld_col_end && ((RCW'(ld_row_q) + RCW'(1)) == eff_h);
		rd_col_end = ((CCW'(rd_col_q) + CCW'(1)) == eff_w);
		rd_last    = rd_col_end && ((RCW'(rd_row_q) + RCW'(1)) == eff_h);
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		cfg_ready  = 1'b0;
		scan_start = 1'b0;
		ero_raddr  = {rd_row_q, rd_col_q};
		unique case (state_q)
			beoc_pkg::ST_IDLE: begin
				in_stall  = out_valid_q && out_stall;
				cfg_ready = 1'b1;
				if (in_valid && !in_stall) begin
					if (operation == beoc_pkg::OP_READ) begin
						state_d = beoc_pkg::ST_RDATA;
					end else if (ld_last) begin
						state_d    = beoc_pkg::ST_SCAN;
						scan_start = 1'b1;
					end
				end
			end
			beoc_pkg::ST_RDATA: begin
				state_d = beoc_pkg::ST_IDLE;
			end
			beoc_pkg::ST_SCAN: begin
				ero_raddr = scan_ero_raddr;
				if (scan_status.done) begin
					state_d = beoc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = beoc_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_acc  = in_valid && !in_stall;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign cfg_hit = cfg_acc && ((cfg_index == beoc_pkg::REG_IMAGE_WIDTH)
		|| (cfg_index == beoc_pkg::REG_IMAGE_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= beoc_pkg::ST_IDLE;
			width_q     <= beoc_pkg::SIZE_RESET;
			height_q    <= beoc_pkg::SIZE_RESET;
			ld_row_q    <= '0;
			ld_col_q    <= '0;
			rd_row_q    <= '0;
			rd_col_q    <= '0;
			possible_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_hit) begin
				if (cfg_index == beoc_pkg::REG_IMAGE_WIDTH) begin
					width_q <= cfg_data;
				end else begin
					height_q <= cfg_data;
				end
				ld_row_q <= '0;
				ld_col_q <= '0;
				rd_row_q <= '0;
				rd_col_q <= '0;
			end else if (in_acc && (operation == beoc_pkg::OP_LOAD)) begin
				if (ld_last) begin
					ld_row_q <= '0;
					ld_col_q <= '0;
					rd_row_q <= '0;
					rd_col_q <= '0;
				end else if (ld_col_end) begin
					ld_col_q <= '0;
					ld_row_q <= ld_row_q + ROW_W'(1);
				end else begin
					ld_col_q <= ld_col_q + COL_W'(1);
				end
			end else if (in_acc) begin
				if (rd_last) begin
					rd_row_q <= '0;
					rd_col_q <= '0;
				end else if (rd_col_end) begin
					rd_col_q <= '0;
					rd_row_q <= rd_row_q + ROW_W'(1);
				end else begin
					rd_col_q <= rd_col_q + COL_W'(1);
				end
			end
			if ((state_q == beoc_pkg::ST_SCAN) && scan_status.done) begin
				possible_q <= scan_status.ok;
			end
			// output register: a new word only lands while it is empty or draining
			if (in_acc && (operation == beoc_pkg::OP_LOAD) && !ld_last) begin
				out_valid_q <= 1'b1;
			end else if (state_q == beoc_pkg::ST_RDATA) begin
				out_valid_q <= 1'b1;
			end else if ((state_q == beoc_pkg::ST_SCAN) && scan_status.done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_last_q <= rd_last;
		end
		if (in_acc && (operation == beoc_pkg::OP_LOAD) && !ld_last) begin
			eroded_q       <= 1'b0;
			possible_out_q <= 1'b0;
			last_q         <= 1'b0;
		end else if (state_q == beoc_pkg::ST_RDATA) begin
			eroded_q       <= ero_rdata;
			possible_out_q <= possible_q;
			last_q         <= rd_last_q;
		end else if ((state_q == beoc_pkg::ST_SCAN) && scan_status.done) begin
			eroded_q       <= 1'b0;
			possible_out_q <= scan_status.ok;
			last_q         <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign eroded_black = eroded_q;
	assign possible     = possible_out_q;
	assign last_pixel   = last_q;

	beoc_bitmem #(
		.ADDR_W (ADDR_W)
	) u_img_mem (
		.clk   (clk),
		.we    (in_acc && (operation == beoc_pkg::OP_LOAD)),
		.waddr ({ld_row_q, ld_col_q}),
		.wdata (pixel_black),
		.raddr (img_raddr),
		.rdata (img_rdata)
	);

	beoc_bitmem #(
		.ADDR_W (ADDR_W)
	) u_ero_mem (
		.clk   (clk),
		.we    (ero_we),
		.waddr (ero_waddr),
		.wdata (ero_wdata),
		.raddr (ero_raddr),
		.rdata (ero_rdata)
	);

	beoc_scan #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.img_raddr (img_raddr),
		.img_rdata (img_rdata),
		.ero_raddr (scan_ero_raddr),
		.ero_rdata (ero_rdata),
		.ero_we    (ero_we),
		.ero_waddr (ero_waddr),
		.ero_wdata (ero_wdata),
		.status    (scan_status)
	);

endmodule

`default_nettype wire

>>> rtl/core/beoc_bitmem.sv
// One-bit-wide synchronous memory, one write port and one registered read port.
`default_nettype none

module beoc_bitmem #(
	parameter int ADDR_W = 14
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic              wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic                   rdata
);

	logic mem [0:(2**ADDR_W)-1];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/beoc_scan.sv
// Erosion and coverage sequencer: three row reads per column, sliding 3-column window.
`default_nettype none

module beoc_scan #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  wire logic                                                    clk,
	input  wire logic                                                    arst_n,
	input  wire logic                                                    start,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]                          eff_w,
	input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]                         eff_h,
	output logic [$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH)-1:0]              img_raddr,
	input  wire logic                                                    img_rdata,
	output logic [$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH)-1:0]              ero_raddr,
	input  wire logic                                                    ero_rdata,
	output logic                                                         ero_we,
	output logic [$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH)-1:0]              ero_waddr,
	output logic                                                         ero_wdata,
	output beoc_pkg::scan_status_t                                       status
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int CCW    = $clog2(MAX_WIDTH + 1);
	localparam int RCW    = $clog2(MAX_HEIGHT + 1);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam logic [1:0] TAP_FIRST = 2'd0;
	localparam logic [1:0] TAP_LAST  = 2'd2;

	beoc_pkg::scan_state_t state_q, state_d;
	logic                  erode_q, erode_d;
	logic [ROW_W-1:0]      row_q;
	logic [CCW-1:0]        col_q;
	logic [1:0]            tap_q;

	logic                  vld_s1;
	logic [1:0]            tap_s1;
	logic                  inr_s1;
	logic                  col0_s1;
	logic                  erode_s1;
	logic [ADDR_W-1:0]     waddr_s1;

	logic                  acc_q;
	logic                  win1_q;
	logic                  win2_q;
	logic                  ok_q;

	logic [ROW_W:0]        row_ext;
	logic [COL_W-1:0]      col_idx;
	logic [COL_W-1:0]      col_m1;
	logic                  col_last;
	logic                  row_last;
	logic                  inrange;
	logic [ADDR_W-1:0]     rd_addr;

	logic                  term;
	logic                  col_val;
	logic                  col_done;
	logic                  miss;

	// issue side
	always_comb begin
		row_ext  = {1'b0, row_q} + (ROW_W+1)'(tap_q) - (ROW_W+1)'(1);
		col_idx  = col_q[COL_W-1:0];
		col_m1   = col_idx - COL_W'(1);
		col_last = (col_q == eff_w);
		row_last = ((RCW'(row_q) + RCW'(1)) == eff_h);
		// rows above the top, below the bottom and the extra column are outside
		inrange  = !((row_q == '0) && (tap_q == TAP_FIRST))
			&& !((tap_q == TAP_LAST) && row_last)
			&& !col_last;
		rd_addr   = {row_ext[ROW_W-1:0], col_idx};
		ero_raddr = rd_addr;
		img_raddr = erode_q ? rd_addr : {row_q, col_m1};
	end

	always_comb begin
		state_d = state_q;
		erode_d = erode_q;
		unique case (state_q)
			beoc_pkg::SC_IDLE: begin
				if (start) begin
					state_d = beoc_pkg::SC_RUN;
					erode_d = 1'b1;
				end
			end
			beoc_pkg::SC_RUN: begin
				if ((tap_q == TAP_LAST) && col_last && row_last) begin
					state_d = beoc_pkg::SC_FLUSH;
				end
			end
			beoc_pkg::SC_FLUSH: begin
				if (erode_q) begin
					state_d = beoc_pkg::SC_RUN;
					erode_d = 1'b0;
				end else begin
					state_d = beoc_pkg::SC_DONE;
				end
			end
			beoc_pkg::SC_DONE: begin
				state_d = beoc_pkg::SC_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= beoc_pkg::SC_IDLE;
			erode_q <= 1'b1;
			row_q   <= '0;
			col_q   <= '0;
			tap_q   <= TAP_FIRST;
			vld_s1  <= 1'b0;
			ok_q    <= 1'b1;
		end else begin
			state_q <= state_d;
			erode_q <= erode_d;
			vld_s1  <= (state_q == beoc_pkg::SC_RUN);
			if (state_q == beoc_pkg::SC_RUN) begin
				if (tap_q == TAP_LAST) begin
					tap_q <= TAP_FIRST;
					if (col_last) begin
						col_q <= '0;
						row_q <= row_last ? '0 : row_q + ROW_W'(1);
					end else begin
						col_q <= col_q + CCW'(1);
					end
				end else begin
					tap_q <= tap_q + 2'd1;
				end
			end
			if ((state_q == beoc_pkg::SC_IDLE) && start) begin
				ok_q <= 1'b1;
			end else if (miss) begin
				ok_q <= 1'b0;
			end
		end
	end

	// read data side, handled in the cycle after the issue
	always_comb begin
		term     = inr_s1 ? (erode_s1 ? img_rdata : ero_rdata) : erode_s1;
		if (tap_s1 == TAP_FIRST) begin
			col_val = term;
		end else begin
			col_val = erode_s1 ? (acc_q & term) : (acc_q | term);
		end
		col_done  = vld_s1 && (tap_s1 == TAP_LAST);
		ero_we    = col_done && erode_s1 && !col0_s1;
		ero_waddr = waddr_s1;
		ero_wdata = win2_q & win1_q & col_val;
		// in the coverage pass the image read returns the centre pixel
		miss      = col_done && !erode_s1 && !col0_s1 && img_rdata
			&& !(win2_q | win1_q | col_val);
	end

	always_ff @(posedge clk) begin
		tap_s1   <= tap_q;
		inr_s1   <= inrange;
		col0_s1  <= (col_q == '0);
		erode_s1 <= erode_q;
		waddr_s1 <= {row_q, col_m1};
		if (vld_s1) begin
			acc_q <= col_val;
		end
		if (col_done) begin
			if (col0_s1) begin
				win1_q <= col_val;
				win2_q <= erode_s1;
			end else begin
				win2_q <= win1_q;
				win1_q <= col_val;
			end
		end
	end

	assign status.done = (state_q == beoc_pkg::SC_DONE);
	assign status.ok   = ok_q;

endmodule

`default_nettype wire

>>> rtl/core/beoc_chk.sv
// Port-level checks for the binary erosion opening check, bound to the top level.
`default_nettype none

module beoc_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic operation,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic eroded_black,
	input wire logic possible,
	input wire logic last_pixel,
	input wire logic cfg_ready
);

	// a stalled result word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({eroded_black, possible, last_pixel}))
		else $error("stalled result word changed");

	// a read waits in ST_RDATA for the memory, so no word can follow at once
	a_read_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (operation == beoc_pkg::OP_READ) |=> in_stall)
		else $error("word taken during read latency");

	// while busy neither input nor configuration is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready |-> in_stall)
		else $error("input taken while busy");

endmodule

bind binary_erosion_opening_check beoc_chk u_chk (.*);

`default_nettype wire
